>>> rtl/core/brr_pkg.sv
package brr_pkg;

  localparam int DATA_W      = 32;
  localparam int CNT_W       = 8;
  localparam int ADDR_W      = 3;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  localparam logic [CNT_W-1:0]  ATTEMPT_CAP = CNT_W'(255);
  localparam logic [DATA_W-1:0] RESET_RANGE = DATA_W'(1009);
  localparam logic [DATA_W-1:0] RESET_SEED  = DATA_W'(32'h1234_5678);
  localparam logic [DATA_W-1:0] RESET_THR   =
    DATA_W'((64'h1_0000_0000 - 64'(RESET_RANGE)) % 64'(RESET_RANGE));

  // register index, taken from the word address bit
  localparam logic REG_RANGE = 1'b0;
  localparam logic REG_SEED  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } brr_div_st_t;

  function automatic logic [DATA_W-1:0] brr_xorshift(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] x;
    x = w;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage

>>> rtl/core/brr_front.sv
module brr_front
  import brr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_draw,
  output logic in_stall,
  input  logic hold,
  output logic req_pending,
  input  logic req_pop
);

  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              push;

  assign in_stall    = hold || (cnt_r == QCNT_W'(QUEUE_DEPTH));
  // drop items that carry no request
  assign push        = in_valid && !in_stall && in_draw;
  assign req_pending = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !req_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && req_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/brr_div.sv
module brr_div
  import brr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output brr_div_st_t       st,
  output logic [DATA_W-1:0] rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    dvd_r;
  logic [DATA_W-1:0]    dsr_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W:0]      trial;
  logic [DATA_W-1:0]    rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[DATA_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DATA_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DATA_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign rem     = rem_r;

endmodule

>>> rtl/core/brr_back.sv
module brr_back
  import brr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_pending,
  output logic              req_pop,
  input  logic [DATA_W-1:0] range_size,
  input  logic [DATA_W-1:0] thr,
  input  logic              seed_wr,
  input  logic [DATA_W-1:0] seed_val,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_value,
  output logic [CNT_W-1:0]  out_attempts
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CHECK = 1'b1;

  logic              state_r;
  logic [DATA_W-1:0] gen_r;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  tries_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [CNT_W-1:0]  out_attempts_r;

  logic [DATA_W-1:0] x_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              step;

  assign x_nxt    = brr_xorshift(gen_r);
  assign prod_nxt = PROD_W'(x_nxt) * PROD_W'(range_size);
  assign accept   = (prod_r[DATA_W-1:0] >= thr) || (tries_r == ATTEMPT_CAP);
  assign out_free = !out_valid_r || !out_stall;

  assign req_pop  = (state_r == ST_IDLE) && req_pending && !seed_wr;
  assign load_out = (state_r == ST_CHECK) && accept && out_free;
  assign step     = req_pop || ((state_r == ST_CHECK) && !accept);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= RESET_SEED;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_pop) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (seed_wr) begin
        gen_r <= seed_val;
      end else if (step) begin
        gen_r <= x_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod_r <= prod_nxt;
    end
    if (req_pop) begin
      tries_r <= CNT_W'(1);
    end else if (step) begin
      tries_r <= tries_r + CNT_W'(1);
    end
    if (load_out) begin
      out_value_r    <= prod_r[PROD_W-1:DATA_W];
      out_attempts_r <= tries_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_attempts = out_attempts_r;

endmodule

>>> rtl/core/bounded_random_rejection.sv
// Unbiased random integers in [0, range_size) by multiply-and-reject over a
// 32-bit xorshift (13/17/5) generator. Each in_draw=1 item gives one result
// with the value and the number of generator steps used (capped at 255);
// an item with in_draw=0 is taken and gives nothing. A request leaves the
// two-entry request queue and is served by the single xorshift-and-multiply
// unit, one attempt after another, until its result is loaded for output.
// Writing range_size (offset 0x0) starts a bit-serial remainder unit that
// holds in_stall high while it runs; writing seed (offset 0x4) reloads the
// generator at once. Reads return the last written register values.
module bounded_random_rejection
  import brr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_draw,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_value,
  output logic [CNT_W-1:0]  out_attempts,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] range_r;
  logic [DATA_W-1:0] seed_r;
  logic [DATA_W-1:0] thr_r;
  logic              wr_en;
  logic              range_wr;
  logic              seed_wr;
  logic              div_start;
  logic              req_pending;
  logic              req_pop;
  brr_div_st_t       div_st;
  logic [DATA_W-1:0] div_rem;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign range_wr  = wr_en && (paddr[2] == REG_RANGE);
  assign seed_wr   = wr_en && (paddr[2] == REG_SEED);
  assign div_start = range_wr;
  assign prdata    = (paddr[2] == REG_SEED) ? seed_r : range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RESET_RANGE;
      seed_r  <= RESET_SEED;
      thr_r   <= RESET_THR;
    end else begin
      if (range_wr) begin
        range_r <= pwdata;
        if (pwdata == '0) begin
          thr_r <= '0;
        end
      end else if (div_st.done) begin
        thr_r <= div_rem;
      end
      if (seed_wr) begin
        seed_r <= pwdata;
      end
    end
  end

  brr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_draw     (in_draw),
    .in_stall    (in_stall),
    .hold        (div_st.busy),
    .req_pending (req_pending),
    .req_pop     (req_pop)
  );

  brr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DATA_W'(0) - pwdata),
    .divisor  (pwdata),
    .st       (div_st),
    .rem      (div_rem)
  );

  brr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_pending  (req_pending),
    .req_pop      (req_pop),
    .range_size   (range_r),
    .thr          (thr_r),
    .seed_wr      (seed_wr),
    .seed_val     (pwdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_attempts (out_attempts)
  );

  a_div_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> in_stall)
    else $error("input taken while threshold is recomputed");

  a_range_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (range_wr && (pwdata != '0)) |=> in_stall)
    else $error("range write did not hold the input");

  a_attempts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_attempts != '0))
    else $error("result with zero attempts");

endmodule
